FILE: design/ata_identify_geometry_translate_macros.svh
// ============================================================================
// ata identify geometry translate assertion macros
// clocked assertion helpers used by the translate design file
// ============================================================================
`ifndef ATA_IDENTIFY_GEOMETRY_TRANSLATE_MACROS_SVH
`define ATA_IDENTIFY_GEOMETRY_TRANSLATE_MACROS_SVH

// property checked on every clock edge outside reset
`define AIGT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("aigt assertion failed");

// implication checked on every clock edge outside reset
`define AIGT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aigt implication failed");

`endif

FILE: design/aigt_pkg.sv
// ============================================================================
// aigt_pkg
// types and constants of the identify geometry translate pipeline
// ============================================================================
package aigt_pkg;

    localparam int IN_W  = 104;
    localparam int OUT_W = 96;

    localparam logic [31:0] BRK_16   = 32'd1032192;
    localparam logic [31:0] BRK_32   = 32'd2064384;
    localparam logic [31:0] BRK_64   = 32'd4128768;
    localparam logic [31:0] BRK_128  = 32'd8257536;
    // first lba count whose quotient by 255*63 exceeds the cylinder limit
    localparam logic [31:0] SAT_255  = 32'd16466625;

    localparam logic [13:0] DIV_16   = 14'd1008;
    localparam logic [13:0] DIV_32   = 14'd2016;
    localparam logic [13:0] DIV_64   = 14'd4032;
    localparam logic [13:0] DIV_128  = 14'd8064;
    localparam logic [13:0] DIV_255  = 14'd16065;

    localparam logic [7:0]  HEADS_16  = 8'd16;
    localparam logic [7:0]  HEADS_32  = 8'd32;
    localparam logic [7:0]  HEADS_64  = 8'd64;
    localparam logic [7:0]  HEADS_128 = 8'd128;
    localparam logic [7:0]  HEADS_255 = 8'd255;

    localparam logic [5:0]  SECT_PER_TRACK = 6'd63;
    localparam logic [15:0] CYL_LIMIT      = 16'd1024;
    localparam logic [10:0] CYL_SAT        = 11'd1024;
    localparam logic [15:0] HEAD_MAX       = 16'd255;
    localparam logic [15:0] SECT_MAX       = 16'd63;
    localparam logic [7:0]  MANY_HEADS_MIN = 8'd8;
    localparam int          CAP_DMA_BIT    = 8;
    localparam int          CAP_LBA_BIT    = 9;

    localparam int REM_W       = 24;
    localparam int DIV_W       = 14;
    localparam int SHIFT_W     = 26;
    localparam int QBITS       = 12;
    localparam int BPS         = 2;
    localparam int DIV_STAGES  = QBITS / BPS;

    typedef struct packed {
        logic              unit;
        logic [15:0]       cyl;
        logic [7:0]        ph;
        logic [5:0]        ps;
        logic [31:0]       lba;
        logic              cap_lba;
        logic              cap_dma;
        logic              fits;
        logic              lba_nz;
        logic              sat;
        logic [7:0]        heads;
        logic [DIV_W-1:0]  divisor;
        logic [REM_W-1:0]  rem;
        logic [QBITS-1:0]  quot;
    } t_item;

    typedef struct packed {
        logic        dma_capable;
        logic        lba_capable;
        logic        many_heads;
        logic [5:0]  logical_sectors;
        logic [7:0]  logical_heads;
        logic [10:0] logical_cylinders;
        logic        unit_out;
        logic [31:0] max_sector_count;
        logic [5:0]  drive_sectors;
        logic [7:0]  drive_heads;
        logic [15:0] drive_cylinders;
    } t_rec;

endpackage

FILE: design/ata_identify_geometry_translate.sv
// ============================================================================
// ata_identify_geometry_translate
// builds a drive parameter record with lba assist chs translation
// ============================================================================
// One item enters per clock unless the output stalls; its record passes one
// decode stage (range checks, head breakpoints, divisor select, saturation
// test), six long division stages of two quotient bits each for
// cylinders = lba / (heads * 63), and one output register. Each stage holds
// its item until the next one frees, so a stalled output keeps up to eight
// items in flight and drops or repeats none. No clearing pass after reset.
`include "ata_identify_geometry_translate_macros.svh"

module ata_identify_geometry_translate (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // unit, cylinders_word, heads_word, sectors_word, capability_word, lba_count
    input  logic [aigt_pkg::IN_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // drive_cylinders, drive_heads, drive_sectors, max_sector_count, unit_out,
    // logical_cylinders, logical_heads, logical_sectors, many_heads,
    // lba_capable, dma_capable
    output logic [aigt_pkg::OUT_W-1:0] o_m_tdata
);
    import aigt_pkg::*;

    localparam int NSTG = DIV_STAGES + 1;

    t_item              r_stg [NSTG];
    logic  [NSTG-1:0]   r_vld;
    logic  [NSTG-1:0]   w_rdy;
    t_item              n_stg [NSTG];
    t_rec               r_out;
    t_rec               n_out;
    logic               r_out_vld;
    logic               w_out_rdy;

    logic               w_unit;
    logic [15:0]        w_cyl;
    logic [15:0]        w_hd;
    logic [15:0]        w_sec;
    logic [15:0]        w_cap;
    logic [31:0]        w_lba;

    assign w_unit = i_s_tdata[0];
    assign w_cyl  = i_s_tdata[16:1];
    assign w_hd   = i_s_tdata[32:17];
    assign w_sec  = i_s_tdata[48:33];
    assign w_cap  = i_s_tdata[64:49];
    assign w_lba  = i_s_tdata[96:65];

    // stage ready chain
    assign w_out_rdy = !r_out_vld || i_m_tready;
    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || w_out_rdy;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end
    assign o_s_tready = w_rdy[0];

    // decode stage
    always_comb begin
        n_stg[0]         = '0;
        n_stg[0].unit    = w_unit;
        n_stg[0].cyl     = w_cyl;
        n_stg[0].ph      = (w_hd != '0 && w_hd <= HEAD_MAX) ? w_hd[7:0] : '0;
        n_stg[0].ps      = (w_sec != '0 && w_sec <= SECT_MAX) ? w_sec[5:0] : '0;
        n_stg[0].lba     = w_lba;
        n_stg[0].cap_lba = w_cap[CAP_LBA_BIT];
        n_stg[0].cap_dma = w_cap[CAP_DMA_BIT];
        n_stg[0].fits    = (w_cyl != '0) && (w_cyl <= CYL_LIMIT)
                           && (n_stg[0].ph != '0) && (n_stg[0].ps != '0);
        n_stg[0].lba_nz  = (w_lba != '0);
        n_stg[0].sat     = (w_lba >= SAT_255);
        priority if (w_lba <= BRK_16) begin
            n_stg[0].heads   = HEADS_16;
            n_stg[0].divisor = DIV_16;
        end else if (w_lba <= BRK_32) begin
            n_stg[0].heads   = HEADS_32;
            n_stg[0].divisor = DIV_32;
        end else if (w_lba <= BRK_64) begin
            n_stg[0].heads   = HEADS_64;
            n_stg[0].divisor = DIV_64;
        end else if (w_lba <= BRK_128) begin
            n_stg[0].heads   = HEADS_128;
            n_stg[0].divisor = DIV_128;
        end else begin
            n_stg[0].heads   = HEADS_255;
            n_stg[0].divisor = DIV_255;
        end
        n_stg[0].rem  = n_stg[0].sat ? '0 : w_lba[REM_W-1:0];
        n_stg[0].quot = '0;
    end

    // restoring division, two quotient bits per stage
    for (genvar s = 1; s < NSTG; s++) begin : g_div
        always_comb begin
            logic [SHIFT_W-1:0] l_sh;
            logic [SHIFT_W-1:0] l_rem;
            int                 l_idx;
            n_stg[s] = r_stg[s-1];
            for (int b = 0; b < BPS; b++) begin
                l_idx = QBITS - 1 - ((s - 1) * BPS + b);
                l_sh  = SHIFT_W'(r_stg[s-1].divisor) << l_idx;
                l_rem = SHIFT_W'(n_stg[s].rem);
                if (l_rem >= l_sh) begin
                    n_stg[s].rem         = REM_W'(l_rem - l_sh);
                    n_stg[s].quot[l_idx] = 1'b1;
                end
            end
        end
    end

    // record assembly
    always_comb begin
        t_item l_it;
        l_it                    = r_stg[NSTG-1];
        n_out                   = '0;
        n_out.drive_cylinders   = l_it.cyl;
        n_out.drive_heads       = l_it.ph;
        n_out.drive_sectors     = l_it.ps;
        n_out.max_sector_count  = l_it.lba;
        n_out.unit_out          = l_it.unit;
        n_out.lba_capable       = l_it.cap_lba;
        n_out.dma_capable       = l_it.cap_dma;
        priority if (l_it.fits) begin
            n_out.logical_cylinders = l_it.cyl[10:0];
            n_out.logical_heads     = l_it.ph;
            n_out.logical_sectors   = l_it.ps;
        end else if (l_it.lba_nz) begin
            n_out.logical_cylinders = l_it.sat ? CYL_SAT : l_it.quot[10:0];
            n_out.logical_heads     = l_it.heads;
            n_out.logical_sectors   = SECT_PER_TRACK;
        end else begin
            n_out.logical_cylinders = '0;
            n_out.logical_heads     = '0;
            n_out.logical_sectors   = '0;
        end
        n_out.many_heads = (n_out.logical_heads > MANY_HEADS_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_out_rdy) begin
                r_out_vld <= r_vld[NSTG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
        if (w_out_rdy) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {(OUT_W - $bits(t_rec))'(0), r_out};

    `AIGT_ASSERT(a_cyl_limit, !r_out_vld || r_out.logical_cylinders <= CYL_SAT)
    `AIGT_ASSERT(a_geom_zero, !r_out_vld
        || ((r_out.logical_sectors == '0) == (r_out.logical_heads == '0)))
    `AIGT_ASSERT_IMPL(a_accept_loads, i_s_tvalid && o_s_tready, r_vld[0])

endmodule
